### rtl/tcp_pkg.sv
// Turtle canvas plotter package: command codes, heading codes, register
// indexes, field widths and the control/status structs of the canvas walker.
// No dependencies.
package tcp_pkg;

  // Default canvas size
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int DIST_W   = 8;
  localparam int PROBE_W  = 6;
  localparam int POS_W    = 6;
  localparam int HEAD_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_COLS_IN_USE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RST    = 7'd64;

  // Command codes; the two highest codes are ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_PEN_UP     = 3'd0,
    CMD_PEN_DOWN   = 3'd1,
    CMD_TURN_LEFT  = 3'd2,
    CMD_TURN_RIGHT = 3'd3,
    CMD_FORWARD    = 3'd4,
    CMD_READ       = 3'd5
  } cmd_t;

  // Heading codes
  localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd3;

  // Request to the canvas walker
  typedef struct packed {
    logic start;   // begin a stroke or a probe this cycle
    logic probe;   // read one cell instead of marking
  } tcp_ctl_t;

  // Status from the canvas walker
  typedef struct packed {
    logic busy;    // clearing pass after reset
    logic done;    // stroke written back or probe data ready
    logic rd_bit;  // probed bit, valid with done
  } tcp_sts_t;

endpackage

### rtl/tcp_if.sv
// Valid/ready channel interfaces of the turtle canvas plotter: command,
// result and register write. Depends on tcp_pkg.
interface tcp_cmd_if;
  import tcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [DIST_W-1:0]   distance;
  logic [PROBE_W-1:0]  probe_row;
  logic [PROBE_W-1:0]  probe_col;
  modport source (output valid, cmd, distance, probe_row, probe_col, input ready);
  modport sink   (input valid, cmd, distance, probe_row, probe_col, output ready);
endinterface

interface tcp_res_if;
  import tcp_pkg::*;
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pos_row;
  logic [POS_W-1:0]   pos_col;
  logic [HEAD_W-1:0]  heading;
  logic               pen_is_down;
  logic               cell_value;
  modport source (output valid, pos_row, pos_col, heading, pen_is_down, cell_value,
                  input ready);
  modport sink   (input valid, pos_row, pos_col, heading, pen_is_down, cell_value,
                  output ready);
endinterface

interface tcp_cfg_if;
  import tcp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_idx;
  logic [CFG_DATA_W-1:0]  wdata;
  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

### rtl/turtle_canvas_plotter.sv
// Top level of the turtle canvas plotter: turtle state, register file,
// command decode and result register. Depends on tcp_pkg, tcp_if and tcp_canvas.
//
// Usage:
//   in_ch   command requests (cmd, distance, probe_row, probe_col), valid/ready.
//   out_ch  one result per command: position, heading, pen and probed cell.
//   cfg_ch  register writes: index 0 rows in use, index 1 columns in use;
//           always ready, write only while the plotter is idle.
// Flow, from the accepting edge to the edge where out_ch.valid rises:
//   pen, turn, ignored codes and forward with the pen up: straight to the hold
//   state. read cell inside the area: one probe read first; outside: none.
//   forward with the pen down: a canvas pass over the rows touched; a horizontal
//   stroke touches one row, a vertical one up to MAX_ROWS rows. The canvas RAM
//   read-modify-write handles one row per cycle in that pass.
//   A new command is taken only once the previous result has entered the
//   result register; one command is processed at a time.
// Reset: pen up, heading down, position 0/0, both sizes 64; the canvas RAM is
//   then cleared one row per cycle over every row, with in_ch.ready low.
// Stall: a result waits in the result register while out_ch.ready is low; the
//   next command may be taken meanwhile and waits for the register to free.
module turtle_canvas_plotter #(
  parameter int MAX_ROWS = tcp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcp_pkg::MAX_COLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcp_cmd_if.sink   in_ch,
  tcp_res_if.source out_ch,
  tcp_cfg_if.sink   cfg_ch
);
  import tcp_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RXW = ((RW > DIST_W) ? RW : DIST_W) + 1;
  localparam int CXW = ((CW > DIST_W) ? CW : DIST_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t                 state_r;
  logic [CFG_DATA_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic                   pen_r, pen_nxt;
  logic [HEAD_W-1:0]      head_r, head_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [CW-1:0]          col_r, col_nxt;
  logic                   probe_r;
  logic                   cell_r;

  logic                   out_valid_r;
  logic [POS_W-1:0]       out_row_r, out_col_r;
  logic [HEAD_W-1:0]      out_head_r;
  logic                   out_pen_r, out_cell_r;

  logic                   in_fire, out_free;
  cmd_t                   cmd;
  logic [RXW-1:0]         row_x, dist_rx, rows_x, rows_eff, row_end, pr_x;
  logic [CXW-1:0]         col_x, dist_cx, cols_x, cols_eff, col_end, pc_x;
  logic [RXW-1:0]         up_d, up_row, dn_d, dn_row;
  logic [CXW-1:0]         lf_d, lf_col, rt_d, rt_col;
  logic [RXW-1:0]         s_row_lo, s_row_hi;
  logic [CXW-1:0]         s_col_lo, s_col_hi;
  logic [RXW-1:0]         new_row_x;
  logic [CXW-1:0]         new_col_x;
  logic                   need_unit, probe_cmd, probe_in_area;

  tcp_ctl_t               ctl;
  tcp_sts_t               sts;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !sts.busy;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cmd       = cmd_t'(in_ch.cmd);

  // Widen position, distance and sizes for compare and clip
  assign row_x    = RXW'(row_r);
  assign col_x    = CXW'(col_r);
  assign dist_rx  = RXW'(in_ch.distance);
  assign dist_cx  = CXW'(in_ch.distance);
  assign pr_x     = RXW'(in_ch.probe_row);
  assign pc_x     = CXW'(in_ch.probe_col);
  assign rows_x   = RXW'(rows_cfg_r);
  assign cols_x   = CXW'(cols_cfg_r);
  assign rows_eff = (rows_x == '0) ? RXW'(1) :
                    (rows_x > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : rows_x;
  assign cols_eff = (cols_x == '0) ? CXW'(1) :
                    (cols_x > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : cols_x;
  assign row_end  = rows_eff - RXW'(1);
  assign col_end  = cols_eff - CXW'(1);

  // Clip the move in each direction
  assign up_d   = (dist_rx > row_x) ? row_x : dist_rx;
  assign up_row = row_x - up_d;
  assign dn_d   = (row_x >= row_end) ? '0 :
                  (dist_rx > (row_end - row_x)) ? (row_end - row_x) : dist_rx;
  assign dn_row = row_x + dn_d;
  assign lf_d   = (dist_cx > col_x) ? col_x : dist_cx;
  assign lf_col = col_x - lf_d;
  assign rt_d   = (col_x >= col_end) ? '0 :
                  (dist_cx > (col_end - col_x)) ? (col_end - col_x) : dist_cx;
  assign rt_col = col_x + rt_d;

  assign probe_in_area = (pr_x < rows_eff) && (pc_x < cols_eff);

  // Decode the command into the next turtle state and a walker request
  always_comb begin
    pen_nxt   = pen_r;
    head_nxt  = head_r;
    new_row_x = row_x;
    new_col_x = col_x;
    s_row_lo  = row_x;
    s_row_hi  = row_x;
    s_col_lo  = col_x;
    s_col_hi  = col_x;
    need_unit = 1'b0;
    probe_cmd = 1'b0;
    unique case (cmd)
      CMD_PEN_UP:     pen_nxt  = 1'b0;
      CMD_PEN_DOWN:   pen_nxt  = 1'b1;
      CMD_TURN_LEFT:  head_nxt = head_r + 2'd1;
      CMD_TURN_RIGHT: head_nxt = head_r - 2'd1;
      CMD_FORWARD: begin
        need_unit = pen_r;
        unique case (head_r)
          HEAD_UP: begin
            new_row_x = up_row;
            s_row_lo  = up_row;
          end
          HEAD_LEFT: begin
            new_col_x = lf_col;
            s_col_lo  = lf_col;
          end
          HEAD_DOWN: begin
            new_row_x = dn_row;
            s_row_hi  = dn_row;
          end
          default: begin
            // facing right
            new_col_x = rt_col;
            s_col_hi  = rt_col;
          end
        endcase
      end
      CMD_READ: begin
        probe_cmd = 1'b1;
        need_unit = probe_in_area;
        s_row_lo  = pr_x;
        s_row_hi  = pr_x;
        s_col_lo  = pc_x;
        s_col_hi  = pc_x;
      end
      default: begin
        // ignored codes change nothing
      end
    endcase
    row_nxt = new_row_x[RW-1:0];
    col_nxt = new_col_x[CW-1:0];
  end

  assign ctl.start = in_fire && need_unit;
  assign ctl.probe = probe_cmd;

  tcp_canvas #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_canvas (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .row_lo (s_row_lo[RW-1:0]),
    .row_hi (s_row_hi[RW-1:0]),
    .col_lo (s_col_lo[CW-1:0]),
    .col_hi (s_col_hi[CW-1:0]),
    .sts    (sts)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_SIZE_RST;
      cols_cfg_r <= CFG_SIZE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_idx)
        CFG_ROWS_IN_USE: rows_cfg_r <= cfg_ch.wdata;
        CFG_COLS_IN_USE: cols_cfg_r <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  // Command sequencer, turtle state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pen_r       <= 1'b0;
      head_r      <= HEAD_DOWN;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless a held one replaces it
      if (out_valid_r && out_ch.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            pen_r   <= pen_nxt;
            head_r  <= head_nxt;
            row_r   <= row_nxt;
            col_r   <= col_nxt;
            probe_r <= probe_cmd;
            cell_r  <= 1'b0;
            state_r <= need_unit ? S_RUN : S_HOLD;
          end
        end
        S_RUN: begin
          if (sts.done) begin
            cell_r  <= probe_r && sts.rd_bit;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_x[POS_W-1:0];
            out_col_r   <= col_x[POS_W-1:0];
            out_head_r  <= head_r;
            out_pen_r   <= pen_r;
            out_cell_r  <= cell_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_row     = out_row_r;
  assign out_ch.pos_col     = out_col_r;
  assign out_ch.heading     = out_head_r;
  assign out_ch.pen_is_down = out_pen_r;
  assign out_ch.cell_value  = out_cell_r;

  // An accepted request always leaves the idle state
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted request did not start processing");

  // Walker completions only come while a request waits on them
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == S_RUN))
    else $error("walker completed with no request pending");

  // A held result enters the result register as soon as it is free
  a_hold_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_HOLD) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("held result was not loaded into the result register");

endmodule

### rtl/tcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tcp_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tcp_canvas.sv
// Canvas walker: clears the canvas RAM after reset, marks strokes by
// read-modify-write one row per cycle, and reads single cells.
// Depends on tcp_pkg and tcp_ram.
module tcp_canvas #(
  parameter  int MAX_ROWS = tcp_pkg::MAX_ROWS_DEF,
  parameter  int MAX_COLS = tcp_pkg::MAX_COLS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcp_pkg::tcp_ctl_t ctl,
  input  logic [RW-1:0]    row_lo,
  input  logic [RW-1:0]    row_hi,
  input  logic [CW-1:0]    col_lo,
  input  logic [CW-1:0]    col_hi,
  output tcp_pkg::tcp_sts_t sts
);
  import tcp_pkg::*;

  localparam logic [RW-1:0] END_ROW = RW'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    U_CLEAR,
    U_IDLE,
    U_READ,
    U_DRAIN,
    U_PROBE
  } ustate_t;

  ustate_t               state_r, state_nxt;
  logic [RW-1:0]         rd_row_r, rd_row_nxt;
  logic [RW-1:0]         wr_row_r, wr_row_nxt;
  logic [RW-1:0]         row_hi_r, row_hi_nxt;
  logic [MAX_COLS-1:0]   mask_r, mask_nxt;
  logic [CW-1:0]         bit_idx_r, bit_idx_nxt;
  logic [MAX_COLS-1:0]   col_mask;

  logic                  ram_we;
  logic [RW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_raddr;
  logic [MAX_COLS-1:0]   ram_wdata;
  logic [MAX_COLS-1:0]   ram_rdata;

  tcp_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Build the column span mask of a new stroke
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (CW'(i) >= col_lo) && (CW'(i) <= col_hi);
    end
  end

  // Sequence the clearing pass, stroke write-back and probe read
  always_comb begin
    state_nxt   = state_r;
    rd_row_nxt  = rd_row_r;
    wr_row_nxt  = wr_row_r;
    row_hi_nxt  = row_hi_r;
    mask_nxt    = mask_r;
    bit_idx_nxt = bit_idx_r;
    ram_raddr   = rd_row_r;
    ram_waddr   = wr_row_r;
    ram_we      = 1'b0;
    ram_wdata   = ram_rdata | mask_r;
    unique case (state_r)
      U_CLEAR: begin
        ram_we     = 1'b1;
        ram_wdata  = '0;
        wr_row_nxt = wr_row_r + RW'(1);
        if (wr_row_r == END_ROW) begin
          state_nxt = U_IDLE;
        end
      end
      U_IDLE: begin
        ram_raddr = row_lo;
        if (ctl.start) begin
          wr_row_nxt  = row_lo;
          rd_row_nxt  = row_lo + RW'(1);
          row_hi_nxt  = row_hi;
          mask_nxt    = col_mask;
          bit_idx_nxt = col_lo;
          if (ctl.probe) begin
            state_nxt = U_PROBE;
          end else if (row_lo == row_hi) begin
            state_nxt = U_DRAIN;
          end else begin
            state_nxt = U_READ;
          end
        end
      end
      U_READ: begin
        // write back the previous row while the next one is read
        ram_we     = 1'b1;
        wr_row_nxt = rd_row_r;
        rd_row_nxt = rd_row_r + RW'(1);
        if (rd_row_r == row_hi_r) begin
          state_nxt = U_DRAIN;
        end
      end
      U_DRAIN: begin
        ram_we    = 1'b1;
        state_nxt = U_IDLE;
      end
      U_PROBE: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  // Hold state and walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= U_CLEAR;
      wr_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_row_r  <= wr_row_nxt;
      rd_row_r  <= rd_row_nxt;
      row_hi_r  <= row_hi_nxt;
      mask_r    <= mask_nxt;
      bit_idx_r <= bit_idx_nxt;
    end
  end

  assign sts.busy   = (state_r == U_CLEAR);
  assign sts.done   = (state_r == U_DRAIN) || (state_r == U_PROBE);
  assign sts.rd_bit = ram_rdata[bit_idx_r];

  // A completion never repeats in the next cycle
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done)
    else $error("canvas walker signaled done twice in a row");

  // Rows read and written in one cycle of a stroke always differ
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_READ) |-> (rd_row_r != wr_row_r))
    else $error("stroke read and write hit the same row");

  // No request arrives during the clearing pass
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !ctl.start)
    else $error("request started during clearing pass");

endmodule
